[src/rlc_pkg.sv]
// Shared types, constants and the rounding and saturation function for the RLC branch step.
`timescale 1ns / 1ps

package rlc_pkg;

  localparam int SIG_W     = 32;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 24;
  localparam int PROD_W    = SIG_W + COEF_W;
  // Four products plus growth margin.
  localparam int ACC_W     = PROD_W + 4;
  localparam int Q_W       = ACC_W - COEF_FRAC;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;
  localparam logic signed [ACC_W-1:0]  ROUND_BIAS = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [SIG_W-1:0]  SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0]  SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_CAP_CAP      = 3'd0,
    REG_A_CAP_IND      = 3'd1,
    REG_A_IND_CAP      = 3'd2,
    REG_A_IND_IND      = 3'd3,
    REG_B_CAP          = 3'd4,
    REG_B_IND          = 3'd5,
    REG_NODE0_GROUNDED = 3'd6,
    REG_NODE1_GROUNDED = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic acc_en;
    logic acc_first;
  } mac_ctrl_t;

  // Round half up, drop the coefficient fraction and clamp to the signal range.
  function automatic logic signed [SIG_W-1:0] sat_scale(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic signed [Q_W-1:0]   q;
    r = a + ROUND_BIAS;
    q = r[ACC_W-1:COEF_FRAC];
    if ((&q[Q_W-1:SIG_W-1]) || !(|q[Q_W-1:SIG_W-1])) begin
      sat_scale = q[SIG_W-1:0];
    end else if (q[Q_W-1]) begin
      sat_scale = SIG_MIN;
    end else begin
      sat_scale = SIG_MAX;
    end
  endfunction

endpackage

[src/rlc_mac.sv]
// Shared multiply-accumulate unit with a registered product and a scaled, saturated result.
`timescale 1ns / 1ps

module rlc_mac
  import rlc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [COEF_W-1:0] coef_i,
  input  logic signed [SIG_W-1:0]  sig_i,
  output logic signed [SIG_W-1:0]  result_o
);

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  assign prod_d = PROD_W'(coef_i) * PROD_W'(sig_i);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_en) begin
      if (ctrl_i.acc_first) begin
        acc_d = ACC_W'(prod_q);
      end else begin
        acc_d = acc_q + ACC_W'(prod_q);
      end
    end
  end

  // Datapath registers only; the sequencer decides when their contents count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
    end
  end

  assign result_o = sat_scale(acc_q);

endmodule

[src/series_rlc_state_space_step.sv]
// One time step of a series RLC branch: branch current, state update and next history current.
`timescale 1ns / 1ps

// An item is taken when s_axis_tready is high, which it is whenever no step is in progress.
// Each step runs thirteen products through one shared 32x32 multiplier and accumulator, so
// the next item is taken only after the result has reached the output register, and that
// write waits while the output side still holds back a previous result. The state
// (capacitor voltage, inductor current, previous branch voltage and history current) starts
// at zero after reset; the user must write coefficients through the configuration port
// only while the block is idle, which the block itself does not enforce.

module series_rlc_state_space_step
  import rlc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [31:0] node1_voltage, [63:32] node0_voltage
  input  logic [2*SIG_W-1:0]   s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] branch_current, [63:32] next_history_current
  output logic [2*SIG_W-1:0]   m_axis_tdata
);

  localparam logic [3:0] STEP_CUR_DONE  = 4'd3;
  localparam logic [3:0] STEP_CAP_DONE  = 4'd7;
  localparam logic [3:0] STEP_IND_DONE  = 4'd11;
  localparam logic [3:0] STEP_LAST_ACC  = 4'd13;
  localparam logic [3:0] STEP_LAST      = 4'd14;

  logic signed [COEF_W-1:0] a_cc_q, a_ci_q, a_ic_q, a_ii_q, b_cap_q, b_ind_q;
  logic                     gnd0_q, gnd1_q;

  logic signed [SIG_W-1:0]  cap_q, ind_q, prev_q, hist_q, v_q, cur_q, v_d;
  logic signed [SIG_W-1:0]  v1, v0;
  logic signed [SIG_W:0]    diff;

  logic                     busy_q, out_valid_q;
  logic [3:0]               step_q;
  logic [2*SIG_W-1:0]       out_data_q;

  logic signed [COEF_W-1:0] coef;
  logic signed [SIG_W-1:0]  operand, mac_result;
  mac_ctrl_t                mac_ctrl;
  logic                     in_xfer, finish;

  assign s_axis_tready = !busy_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign finish        = busy_q && (step_q == STEP_LAST) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Branch voltage with grounded terminals forced to zero, clamped to the signal range.
  always_comb begin
    v1   = gnd1_q ? '0 : s_axis_tdata[SIG_W-1:0];
    v0   = gnd0_q ? '0 : s_axis_tdata[2*SIG_W-1:SIG_W];
    diff = (SIG_W+1)'(v1) - (SIG_W+1)'(v0);
    if (diff[SIG_W] != diff[SIG_W-1]) begin
      v_d = diff[SIG_W] ? SIG_MIN : SIG_MAX;
    end else begin
      v_d = diff[SIG_W-1:0];
    end
  end

  // Product issued at each step. The history current terms are ordered so that the new
  // inductor current is already stored when its product is issued.
  always_comb begin
    unique case (step_q)
      4'd0:    begin coef = COEF_ONE; operand = hist_q; end
      4'd1:    begin coef = b_ind_q;  operand = v_q;    end
      4'd2:    begin coef = a_cc_q;   operand = cap_q;  end
      4'd3:    begin coef = a_ci_q;   operand = ind_q;  end
      4'd4:    begin coef = b_cap_q;  operand = prev_q; end
      4'd5:    begin coef = b_cap_q;  operand = v_q;    end
      4'd6:    begin coef = a_ic_q;   operand = cap_q;  end
      4'd7:    begin coef = a_ii_q;   operand = ind_q;  end
      4'd8:    begin coef = b_ind_q;  operand = prev_q; end
      4'd9:    begin coef = b_ind_q;  operand = v_q;    end
      4'd10:   begin coef = b_ind_q;  operand = v_q;    end
      4'd11:   begin coef = a_ic_q;   operand = cap_q;  end
      4'd12:   begin coef = a_ii_q;   operand = ind_q;  end
      default: begin coef = '0;       operand = '0;     end
    endcase
  end

  always_comb begin
    mac_ctrl.acc_en    = busy_q && (step_q >= 4'd1) && (step_q <= STEP_LAST_ACC);
    mac_ctrl.acc_first = (step_q == 4'd1) || (step_q == STEP_CUR_DONE) ||
                         (step_q == STEP_CAP_DONE) || (step_q == STEP_IND_DONE);
  end

  rlc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef),
    .sig_i    (operand),
    .result_o (mac_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cc_q      <= '0;
      a_ci_q      <= '0;
      a_ic_q      <= '0;
      a_ii_q      <= '0;
      b_cap_q     <= '0;
      b_ind_q     <= '0;
      gnd0_q      <= 1'b0;
      gnd1_q      <= 1'b0;
      cap_q       <= '0;
      ind_q       <= '0;
      prev_q      <= '0;
      hist_q      <= '0;
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_A_CAP_CAP:      a_cc_q  <= cfg_data_i;
          REG_A_CAP_IND:      a_ci_q  <= cfg_data_i;
          REG_A_IND_CAP:      a_ic_q  <= cfg_data_i;
          REG_A_IND_IND:      a_ii_q  <= cfg_data_i;
          REG_B_CAP:          b_cap_q <= cfg_data_i;
          REG_B_IND:          b_ind_q <= cfg_data_i;
          REG_NODE0_GROUNDED: gnd0_q  <= cfg_data_i[0];
          REG_NODE1_GROUNDED: gnd1_q  <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (in_xfer) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q != STEP_LAST) begin
          step_q <= step_q + 4'd1;
        end
        if (step_q == STEP_CAP_DONE) begin
          cap_q <= mac_result;
        end
        if (step_q == STEP_IND_DONE) begin
          ind_q <= mac_result;
        end
        if (finish) begin
          hist_q <= mac_result;
          prev_q <= v_q;
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      v_q <= v_d;
    end
    if (busy_q && (step_q == STEP_CUR_DONE)) begin
      cur_q <= mac_result;
    end
    if (finish) begin
      out_data_q <= {mac_result, cur_q};
    end
  end

endmodule

[test/series_rlc_state_space_step_check.sv]
// Checker for the RLC branch step: predicts each result and compares it on the output channel.
`timescale 1ns / 1ps

module series_rlc_state_space_step_check
  import rlc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_W-1:0]    cfg_data_i,
  input  logic                 in_tvalid_i,
  input  logic                 in_tready_i,
  // [31:0] node1_voltage, [63:32] node0_voltage
  input  logic [2*SIG_W-1:0]   in_tdata_i,
  input  logic                 out_tvalid_i,
  input  logic                 out_tready_i,
  // [31:0] branch_current, [63:32] next_history_current
  input  logic [2*SIG_W-1:0]   out_tdata_i,
  output int                   mismatch_count_o,
  output int                   pending_count_o
);

  // Packed so that the layout matches the output tdata word.
  typedef struct packed {
    logic signed [SIG_W-1:0] history;
    logic signed [SIG_W-1:0] current;
  } branch_result_t;

  logic signed [COEF_W-1:0] a_cap_cap, a_cap_ind, a_ind_cap, a_ind_ind, b_cap, b_ind;
  logic                     gnd0, gnd1;
  logic signed [SIG_W-1:0]  cap_v, ind_i, prev_v, hist_i;
  branch_result_t           expected_currents[$];
  int                       mismatches = 0;

  function automatic logic signed [127:0] prod(input logic signed [COEF_W-1:0] c,
                                               input logic signed [SIG_W-1:0] s);
    logic signed [127:0] cw, sw;
    cw = c;
    sw = s;
    return cw * sw;
  endfunction

  function automatic logic signed [SIG_W-1:0] clamp_signal(input logic signed [127:0] x);
    if (x > SIG_MAX) return SIG_MAX;
    if (x < SIG_MIN) return SIG_MIN;
    return x[SIG_W-1:0];
  endfunction

  // Round half toward plus infinity, drop the coefficient fraction, then clamp.
  function automatic logic signed [SIG_W-1:0] round_to_signal(input logic signed [127:0] acc);
    logic signed [127:0] half;
    half = 128'sd1 <<< (COEF_FRAC - 1);
    return clamp_signal((acc + half) >>> COEF_FRAC);
  endfunction

  task automatic step_branch(input logic signed [SIG_W-1:0] node1,
                             input logic signed [SIG_W-1:0] node0);
    logic signed [127:0]     v1w, v0w;
    logic signed [SIG_W-1:0] v, cap_n, ind_n;
    branch_result_t          res;
    v1w = 0;
    v0w = 0;
    if (!gnd1) v1w = node1;
    if (!gnd0) v0w = node0;
    v = clamp_signal(v1w - v0w);
    res.current = round_to_signal(prod(COEF_ONE, hist_i) + prod(b_ind, v));
    cap_n = round_to_signal(prod(a_cap_cap, cap_v) + prod(a_cap_ind, ind_i)
                            + prod(b_cap, prev_v) + prod(b_cap, v));
    ind_n = round_to_signal(prod(a_ind_cap, cap_v) + prod(a_ind_ind, ind_i)
                            + prod(b_ind, prev_v) + prod(b_ind, v));
    cap_v  = cap_n;
    ind_i  = ind_n;
    prev_v = v;
    // The next history current is taken from the already updated state.
    res.history = round_to_signal(prod(a_ind_cap, cap_v) + prod(a_ind_ind, ind_i)
                                  + prod(b_ind, v));
    hist_i = res.history;
    expected_currents = {expected_currents, res};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    branch_result_t got, want;
    if (!rst_ni) begin
      a_cap_cap = '0;
      a_cap_ind = '0;
      a_ind_cap = '0;
      a_ind_ind = '0;
      b_cap     = '0;
      b_ind     = '0;
      gnd0      = 1'b0;
      gnd1      = 1'b0;
      cap_v     = '0;
      ind_i     = '0;
      prev_v    = '0;
      hist_i    = '0;
      expected_currents.delete();
      pending_count_o  <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_A_CAP_CAP:      a_cap_cap = cfg_data_i;
          REG_A_CAP_IND:      a_cap_ind = cfg_data_i;
          REG_A_IND_CAP:      a_ind_cap = cfg_data_i;
          REG_A_IND_IND:      a_ind_ind = cfg_data_i;
          REG_B_CAP:          b_cap     = cfg_data_i;
          REG_B_IND:          b_ind     = cfg_data_i;
          REG_NODE0_GROUNDED: gnd0      = cfg_data_i[0];
          REG_NODE1_GROUNDED: gnd1      = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_tvalid_i && in_tready_i) begin
        step_branch(in_tdata_i[SIG_W-1:0], in_tdata_i[2*SIG_W-1:SIG_W]);
      end
      if (out_tvalid_i && out_tready_i) begin
        got = out_tdata_i;
        if (expected_currents.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = expected_currents.pop_front();
          if (got.current !== want.current) begin
            $display("%0t: branch_current expected %0d, got %0d",
                     $time, want.current, got.current);
            mismatches++;
          end
          if (got.history !== want.history) begin
            $display("%0t: next_history_current expected %0d, got %0d",
                     $time, want.history, got.history);
            mismatches++;
          end
        end
      end
      pending_count_o  <= expected_currents.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

[test/series_rlc_state_space_step_test.sv]
// Top of the RLC branch step testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module series_rlc_state_space_step_test;
  import rlc_pkg::*;

  localparam int                QUIET_LIMIT = 4000;
  localparam int                SETTLE      = 20;
  localparam logic [COEF_W-1:0] COEF_MAX    = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN    = 32'h8000_0000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COEF_W-1:0]    cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [2*SIG_W-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [2*SIG_W-1:0]   m_axis_tdata;

  int mismatches;
  int pending;
  bit steady = 1'b0;
  int long_hold = 0;

  series_rlc_state_space_step u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  series_rlc_state_space_step_check u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_tvalid_i      (s_axis_tvalid),
    .in_tready_i      (s_axis_tready),
    .in_tdata_i       (s_axis_tdata),
    .out_tvalid_i     (m_axis_tvalid),
    .out_tready_i     (m_axis_tready),
    .out_tdata_i      (m_axis_tdata),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none at all in steady stretches.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(21, 60);
  endfunction

  function automatic logic [SIG_W-1:0] pick_voltage();
    case ($urandom_range(0, 9))
      0:       return SIG_MAX;
      1:       return SIG_MIN;
      2:       return '0;
      3, 4, 5: return SIG_W'($urandom_range(0, 131070)) - SIG_W'(65535);
      default: return $urandom();
    endcase
  endfunction

  // Mostly within plus or minus one, so the state does not pin at the rails.
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      8, 9:    return $urandom();
      default: return COEF_W'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_rail();
    return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
  endfunction

  // Random upper bits check that only bit zero of a ground flag counts.
  function automatic logic [COEF_W-1:0] ground_word(input bit on);
    logic [COEF_W-1:0] w;
    w = $urandom();
    w[0] = on;
    return w;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [COEF_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic program_branch(input logic [COEF_W-1:0] a_cc, a_ci, a_ic, a_ii, b_c, b_i,
                                input logic [COEF_W-1:0] gnd0, gnd1);
    write_reg(REG_A_CAP_CAP, a_cc);
    write_reg(REG_A_CAP_IND, a_ci);
    write_reg(REG_A_IND_CAP, a_ic);
    write_reg(REG_A_IND_IND, a_ii);
    write_reg(REG_B_CAP, b_c);
    write_reg(REG_B_IND, b_i);
    write_reg(REG_NODE0_GROUNDED, gnd0);
    write_reg(REG_NODE1_GROUNDED, gnd1);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_step(input logic [SIG_W-1:0] node1, input logic [SIG_W-1:0] node0);
    int gap;
    s_axis_tdata  <= {node0, node1};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering, wait for every outstanding result, then let the pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin : sink
    int stall;
    forever begin
      @(posedge clk_i);
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (stall - 1) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int phase;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Straight after reset every coefficient is zero.
    send_step('0, '0);
    send_step(SIG_MAX, SIG_MIN);
    send_step(SIG_MIN, SIG_MAX);
    drain();

    // Moderate coefficients; the first items overflow the voltage difference.
    program_branch(32'h0080_0000, 32'hFFC0_0000, 32'h0040_0000, 32'h00C0_0000,
                   32'h0020_0000, COEF_ONE, ground_word(1'b0), ground_word(1'b0));
    send_step(SIG_MAX, SIG_MIN);
    send_step(SIG_MIN, SIG_MAX);
    send_step(SIG_MAX, SIG_MAX);
    send_step(SIG_MIN, SIG_MIN);
    send_step('0, '0);
    send_step(SIG_W'(4096), -SIG_W'(4096));
    send_step(SIG_W'(1), '0);
    drain();

    // Terminal zero grounded, then terminal one, then both.
    program_branch(32'h0080_0000, 32'hFFC0_0000, 32'h0040_0000, 32'h00C0_0000,
                   32'h0020_0000, COEF_ONE, ground_word(1'b1), ground_word(1'b0));
    send_step(SIG_MIN, SIG_MAX);
    send_step(SIG_W'(8192), SIG_MIN);
    drain();
    program_branch(32'h0080_0000, 32'hFFC0_0000, 32'h0040_0000, 32'h00C0_0000,
                   32'h0020_0000, COEF_ONE, ground_word(1'b0), ground_word(1'b1));
    send_step(SIG_MAX, SIG_MAX);
    send_step(SIG_MIN, SIG_W'(8192));
    drain();
    program_branch(32'h0080_0000, 32'hFFC0_0000, 32'h0040_0000, 32'h00C0_0000,
                   32'h0020_0000, COEF_ONE, ground_word(1'b1), ground_word(1'b1));
    send_step(SIG_MAX, SIG_MIN);
    send_step(SIG_MIN, SIG_MAX);
    drain();

    // Coefficients at both rails drive every result into saturation.
    program_branch(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                   ground_word(1'b0), ground_word(1'b0));
    send_step(SIG_MAX, SIG_MIN);
    send_step(SIG_MIN, SIG_MAX);
    drain();
    program_branch(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                   ground_word(1'b0), ground_word(1'b0));
    send_step(SIG_MAX, SIG_MIN);
    send_step(SIG_MIN, SIG_MAX);
    drain();

    for (phase = 0; phase < 12; phase++) begin
      steady = (phase % 4 == 1) || (phase == 2);
      if (phase == 6) begin
        program_branch(pick_rail(), pick_rail(), pick_rail(), pick_rail(), pick_rail(),
                       pick_rail(), ground_word($urandom_range(0, 3) == 0),
                       ground_word($urandom_range(0, 3) == 0));
      end else begin
        program_branch(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                       pick_coef(), ground_word($urandom_range(0, 3) == 0),
                       ground_word($urandom_range(0, 3) == 0));
      end
      // Hold the output side off long enough for the block to back up its input.
      if (phase == 2) long_hold = 300;
      repeat (100) send_step(pick_voltage(), pick_voltage());
      drain();
    end
    steady = 1'b0;

    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rlc_pkg.sv
src/rlc_mac.sv
src/series_rlc_state_space_step.sv
test/series_rlc_state_space_step_check.sv
test/series_rlc_state_space_step_test.sv
